### design/segment_line_intersection_unit_macros.svh
// ----------------------------------------------------------------------------
// Segment line intersection unit: assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_LINE_INTERSECTION_UNIT_MACROS_SVH
`define SEGMENT_LINE_INTERSECTION_UNIT_MACROS_SVH

// same-cycle implication
`define SLU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("slu check failed");

// next-cycle implication
`define SLU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("slu check failed");

`endif

### design/slu_pkg.sv
// ----------------------------------------------------------------------------
// Segment line intersection package
// Widths, pipeline payload types and fixed-point helpers.
// ----------------------------------------------------------------------------
package slu_pkg;

    localparam int FRAC_BITS = 16;
    localparam int Q_W       = 32;
    localparam int DIF_W     = Q_W + 1;
    localparam int NUM_W     = DIF_W + FRAC_BITS;
    localparam int QUOT_W    = 32;
    localparam int DIV_LAT   = QUOT_W + 2;
    localparam int PROD_W    = 2 * Q_W;
    localparam int WIDE_W    = PROD_W + 2;
    localparam int TOL_W     = 16;
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(7);

    typedef logic signed [Q_W-1:0]    t_q;
    typedef logic signed [DIF_W-1:0]  t_d;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [WIDE_W-1:0] t_w;

    typedef struct packed {
        t_q sx;
        t_q sy;
        t_q ex;
        t_q ey;
    } t_seg;

    typedef struct packed {
        t_d xlo;
        t_d xhi;
        t_d ylo;
        t_d yhi;
    } t_box;

    typedef struct packed {
        t_seg a;
        t_seg b;
        logic v1;
        logic v2;
    } t_side1;

    typedef struct packed {
        t_seg a;
        t_seg b;
        logic v1;
        logic v2;
        t_q   m1;
        t_q   m2;
        t_prod p1;
        t_prod p2;
    } t_s2;

    typedef struct packed {
        t_seg a;
        t_seg b;
        logic v1;
        logic v2;
        logic par;
        t_q   m1;
        t_q   m2;
        t_q   n1;
        t_q   n2;
    } t_s3;

    typedef struct packed {
        t_seg  a;
        t_seg  b;
        logic  v1;
        logic  v2;
        logic  found;
        t_q    n1;
        t_q    n2;
        t_q    px;
        t_prod pm1;
        t_prod pm2;
    } t_s4;

    typedef struct packed {
        logic v1;
        logic v2;
        logic found;
        t_q   n1;
        t_q   n2;
        t_q   px;
        t_q   py;
        t_w   e1;
        t_w   e2;
        t_box box1;
        t_box box2;
    } t_s5;

    function automatic t_d ext_d(input t_q v);
        return {v[Q_W-1], v};
    endfunction

    function automatic t_w ext_w(input t_q v);
        return {{(WIDE_W-Q_W){v[Q_W-1]}}, v};
    endfunction

    function automatic t_w ext_pw(input t_prod v);
        return {{(WIDE_W-PROD_W){v[PROD_W-1]}}, v};
    endfunction

    function automatic logic [DIF_W-1:0] abs_d(input t_d v);
        return v[DIF_W-1] ? DIF_W'(-v) : DIF_W'(v);
    endfunction

    function automatic logic [WIDE_W-1:0] abs_w(input t_w v);
        return v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
    endfunction

    function automatic t_q sat_q(input t_w v);
        logic [WIDE_W-Q_W:0] top;
        top = v[WIDE_W-1:Q_W-1];
        if ((&top) || !(|top)) begin
            return v[Q_W-1:0];
        end else if (v[WIDE_W-1]) begin
            return {1'b1, {(Q_W-1){1'b0}}};
        end else begin
            return {1'b0, {(Q_W-1){1'b1}}};
        end
    endfunction

endpackage

### design/segment_line_intersection_unit.sv
// ----------------------------------------------------------------------------
// Segment line intersection unit
// Intersects the carrier lines of two segments in signed Q16.16 and flags
// whether the point lies on each segment within the tolerance.
// ----------------------------------------------------------------------------
// One transaction enters per cycle unless the output stalls. The pipeline is
// two restoring dividers in series (slope, then intersection x), each retiring
// one quotient bit per stage, plus six stages of multiply, intercept, evaluate
// and bound checks.
// The whole pipeline holds while a result waits at the output register.
module segment_line_intersection_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [slu_pkg::TOL_W-1:0] i_cfg_wdata,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  slu_pkg::t_q               i_first_start_x,
    input  slu_pkg::t_q               i_first_start_y,
    input  slu_pkg::t_q               i_first_end_x,
    input  slu_pkg::t_q               i_first_end_y,
    input  slu_pkg::t_q               i_second_start_x,
    input  slu_pkg::t_q               i_second_start_y,
    input  slu_pkg::t_q               i_second_end_x,
    input  slu_pkg::t_q               i_second_end_y,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_found,
    output slu_pkg::t_q               o_cross_x,
    output slu_pkg::t_q               o_cross_y,
    output logic                      o_on_first,
    output logic                      o_on_second
);
    import slu_pkg::*;

    logic [TOL_W-1:0] r_tol;
    logic             w_adv;

    t_d     w_dx1, w_dy1, w_dx2, w_dy2;
    logic   r1_valid;
    t_side1 r1;
    t_d     r1_dx1, r1_dy1, r1_dx2, r1_dy2;

    t_q     w_q1, w_q2, w_q3;
    t_side1 r_d1 [DIV_LAT];
    logic   r_d1_v [DIV_LAT];

    t_side1 w_s1;
    t_s2    n2, r2;
    logic   r2_valid;

    t_s3    n3, r3;
    t_d     n3_dm, r3_dm, w_ndiff;
    logic   r3_valid;
    t_s3    r_d2 [DIV_LAT];
    logic   r_d2_v [DIV_LAT];
    t_s3    w_s3;

    t_s4    n4, r4;
    logic   r4_valid;
    t_s5    n5, r5;
    logic   r5_valid;

    logic   n_on1, n_on2;
    logic   r_out_valid, r_found, r_on1, r_on2;
    t_q     r_px, r_py;

    assign w_adv      = !r_out_valid || i_out_ready;
    assign o_in_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    // stage 1: differences and vertical detection
    assign w_dx1 = ext_d(i_first_end_x) - ext_d(i_first_start_x);
    assign w_dy1 = ext_d(i_first_end_y) - ext_d(i_first_start_y);
    assign w_dx2 = ext_d(i_second_end_x) - ext_d(i_second_start_x);
    assign w_dy2 = ext_d(i_second_end_y) - ext_d(i_second_start_y);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1.a    <= '{i_first_start_x, i_first_start_y, i_first_end_x, i_first_end_y};
            r1.b    <= '{i_second_start_x, i_second_start_y, i_second_end_x,
                         i_second_end_y};
            r1.v1   <= (w_dx1 == '0) || (abs_d(w_dx1) < DIF_W'(r_tol));
            r1.v2   <= (w_dx2 == '0) || (abs_d(w_dx2) < DIF_W'(r_tol));
            r1_dx1  <= w_dx1;
            r1_dy1  <= w_dy1;
            r1_dx2  <= w_dx2;
            r1_dy2  <= w_dy2;
        end
    end

    // slopes
    slu_div u_div_m1 (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_num  ({abs_d(r1_dy1), {FRAC_BITS{1'b0}}}),
        .i_den  (abs_d(r1_dx1)),
        .i_neg  (r1_dy1[DIF_W-1] ^ r1_dx1[DIF_W-1]),
        .o_quot (w_q1)
    );

    slu_div u_div_m2 (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_num  ({abs_d(r1_dy2), {FRAC_BITS{1'b0}}}),
        .i_den  (abs_d(r1_dx2)),
        .i_neg  (r1_dy2[DIF_W-1] ^ r1_dx2[DIF_W-1]),
        .o_quot (w_q2)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d1[0] <= r1;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_d1[k] <= r_d1[k-1];
            end
        end
    end

    assign w_s1 = r_d1[DIV_LAT-1];

    // stage 2: slope times start x
    always_comb begin
        n2.a  = w_s1.a;
        n2.b  = w_s1.b;
        n2.v1 = w_s1.v1;
        n2.v2 = w_s1.v2;
        n2.m1 = w_s1.v1 ? '0 : w_q1;
        n2.m2 = w_s1.v2 ? '0 : w_q2;
        n2.p1 = PROD_W'(w_s1.a.sx) * PROD_W'(n2.m1);
        n2.p2 = PROD_W'(w_s1.b.sx) * PROD_W'(n2.m2);
    end

    // stage 3: intercepts and parallel test
    always_comb begin
        n3.a   = r2.a;
        n3.b   = r2.b;
        n3.v1  = r2.v1;
        n3.v2  = r2.v2;
        n3.m1  = r2.m1;
        n3.m2  = r2.m2;
        n3.n1  = r2.v1 ? r2.a.sx : sat_q(ext_w(r2.a.sy) - ext_pw(r2.p1 >>> FRAC_BITS));
        n3.n2  = r2.v2 ? r2.b.sx : sat_q(ext_w(r2.b.sy) - ext_pw(r2.p2 >>> FRAC_BITS));
        n3_dm  = ext_d(r2.m2) - ext_d(r2.m1);
        n3.par = !r2.v1 && !r2.v2 && ((n3_dm == '0) || (abs_d(n3_dm) < DIF_W'(r_tol)));
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2    <= n2;
            r3    <= n3;
            r3_dm <= n3_dm;
        end
    end

    // intersection x of two sloped lines
    assign w_ndiff = ext_d(r3.n1) - ext_d(r3.n2);

    slu_div u_div_x (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_num  ({abs_d(w_ndiff), {FRAC_BITS{1'b0}}}),
        .i_den  (abs_d(r3_dm)),
        .i_neg  (w_ndiff[DIF_W-1] ^ r3_dm[DIF_W-1]),
        .o_quot (w_q3)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d2[0] <= r3;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_d2[k] <= r_d2[k-1];
            end
        end
    end

    assign w_s3 = r_d2[DIV_LAT-1];

    // stage 4: pick x, evaluate both slopes at x
    always_comb begin
        n4.a     = w_s3.a;
        n4.b     = w_s3.b;
        n4.v1    = w_s3.v1;
        n4.v2    = w_s3.v2;
        n4.n1    = w_s3.n1;
        n4.n2    = w_s3.n2;
        n4.found = !(w_s3.v1 && w_s3.v2) && !w_s3.par;
        if (!n4.found) begin
            n4.px = '0;
        end else if (w_s3.v1) begin
            n4.px = w_s3.n1;
        end else if (w_s3.v2) begin
            n4.px = w_s3.n2;
        end else begin
            n4.px = w_q3;
        end
        n4.pm1 = PROD_W'(w_s3.m1) * PROD_W'(n4.px);
        n4.pm2 = PROD_W'(w_s3.m2) * PROD_W'(n4.px);
    end

    // stage 5: line values, y, widened bounding boxes
    always_comb begin
        n5.v1       = r4.v1;
        n5.v2       = r4.v2;
        n5.found    = r4.found;
        n5.n1       = r4.n1;
        n5.n2       = r4.n2;
        n5.px       = r4.px;
        n5.e1       = ext_pw(r4.pm1 >>> FRAC_BITS) + ext_w(r4.n1);
        n5.e2       = ext_pw(r4.pm2 >>> FRAC_BITS) + ext_w(r4.n2);
        n5.py       = r4.found ? sat_q(r4.v1 ? n5.e2 : n5.e1) : '0;
        n5.box1.xlo = ((r4.a.sx < r4.a.ex) ? ext_d(r4.a.sx) : ext_d(r4.a.ex)) - DIF_W'(r_tol);
        n5.box1.xhi = ((r4.a.sx > r4.a.ex) ? ext_d(r4.a.sx) : ext_d(r4.a.ex)) + DIF_W'(r_tol);
        n5.box1.ylo = ((r4.a.sy < r4.a.ey) ? ext_d(r4.a.sy) : ext_d(r4.a.ey)) - DIF_W'(r_tol);
        n5.box1.yhi = ((r4.a.sy > r4.a.ey) ? ext_d(r4.a.sy) : ext_d(r4.a.ey)) + DIF_W'(r_tol);
        n5.box2.xlo = ((r4.b.sx < r4.b.ex) ? ext_d(r4.b.sx) : ext_d(r4.b.ex)) - DIF_W'(r_tol);
        n5.box2.xhi = ((r4.b.sx > r4.b.ex) ? ext_d(r4.b.sx) : ext_d(r4.b.ex)) + DIF_W'(r_tol);
        n5.box2.ylo = ((r4.b.sy < r4.b.ey) ? ext_d(r4.b.sy) : ext_d(r4.b.ey)) - DIF_W'(r_tol);
        n5.box2.yhi = ((r4.b.sy > r4.b.ey) ? ext_d(r4.b.sy) : ext_d(r4.b.ey)) + DIF_W'(r_tol);
    end

    // stage 6: on-segment tests
    always_comb begin
        logic in1, in2, ln1, ln2;
        in1 = (ext_d(r5.px) >= r5.box1.xlo) && (ext_d(r5.px) <= r5.box1.xhi) &&
              (ext_d(r5.py) >= r5.box1.ylo) && (ext_d(r5.py) <= r5.box1.yhi);
        in2 = (ext_d(r5.px) >= r5.box2.xlo) && (ext_d(r5.px) <= r5.box2.xhi) &&
              (ext_d(r5.py) >= r5.box2.ylo) && (ext_d(r5.py) <= r5.box2.yhi);
        ln1 = r5.v1 ? (abs_d(ext_d(r5.px) - ext_d(r5.n1)) < DIF_W'(r_tol))
                    : (abs_w(ext_w(r5.py) - r5.e1) < WIDE_W'(r_tol));
        ln2 = r5.v2 ? (abs_d(ext_d(r5.px) - ext_d(r5.n2)) < DIF_W'(r_tol))
                    : (abs_w(ext_w(r5.py) - r5.e2) < WIDE_W'(r_tol));
        n_on1 = r5.found && in1 && ln1;
        n_on2 = r5.found && in2 && ln2;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4      <= n4;
            r5      <= n5;
            r_found <= r5.found;
            r_px    <= r5.px;
            r_py    <= r5.py;
            r_on1   <= n_on1;
            r_on2   <= n_on2;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r5_valid    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < DIV_LAT; k++) begin
                r_d1_v[k] <= 1'b0;
                r_d2_v[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r1_valid  <= i_in_valid;
            r_d1_v[0] <= r1_valid;
            r_d2_v[0] <= r3_valid;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_d1_v[k] <= r_d1_v[k-1];
                r_d2_v[k] <= r_d2_v[k-1];
            end
            r2_valid    <= r_d1_v[DIV_LAT-1];
            r3_valid    <= r2_valid;
            r4_valid    <= r_d2_v[DIV_LAT-1];
            r5_valid    <= r4_valid;
            r_out_valid <= r5_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_cross_x   = r_px;
    assign o_cross_y   = r_py;
    assign o_on_first  = r_on1;
    assign o_on_second = r_on2;

endmodule

### design/slu_div.sv
// ----------------------------------------------------------------------------
// Segment line intersection: pipelined divider
// Restoring division, one quotient bit per stage, signed result truncated
// toward zero and saturated to the Q range.
// ----------------------------------------------------------------------------
module slu_div (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [slu_pkg::NUM_W-1:0] i_num,
    input  logic [slu_pkg::DIF_W-1:0] i_den,
    input  logic                      i_neg,
    output slu_pkg::t_q               o_quot
);
    import slu_pkg::*;

    localparam int SH_W = DIF_W + QUOT_W;

    logic [NUM_W-1:0]  r_rem [QUOT_W+1];
    logic [DIF_W-1:0]  r_den [QUOT_W+1];
    logic [QUOT_W-1:0] r_quo [QUOT_W+1];
    logic              r_neg [QUOT_W+1];
    logic              r_ovf [QUOT_W+1];
    logic [NUM_W-1:0]  n_rem [QUOT_W];
    logic [QUOT_W-1:0] n_quo [QUOT_W];
    logic              w_ovf;
    logic [WIDE_W-1:0] w_mag;
    t_w                w_val;
    t_q                r_out;

    assign w_ovf = SH_W'(i_num) >= (SH_W'(i_den) << QUOT_W);

    always_comb begin
        for (int k = 0; k < QUOT_W; k++) begin
            logic [SH_W-1:0] shd;
            logic            ge;
            shd      = SH_W'(r_den[k]) << (QUOT_W - 1 - k);
            ge       = SH_W'(r_rem[k]) >= shd;
            n_rem[k] = ge ? NUM_W'(SH_W'(r_rem[k]) - shd) : r_rem[k];
            n_quo[k] = r_quo[k];
            n_quo[k][QUOT_W-1-k] = ge;
        end
    end

    always_comb begin
        w_mag = r_ovf[QUOT_W] ? (WIDE_W'(1) << QUOT_W) : WIDE_W'(r_quo[QUOT_W]);
        w_val = r_neg[QUOT_W] ? -$signed(w_mag) : $signed(w_mag);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_neg[0] <= i_neg;
            r_ovf[0] <= w_ovf;
            for (int k = 0; k < QUOT_W; k++) begin
                r_rem[k+1] <= n_rem[k];
                r_den[k+1] <= r_den[k];
                r_quo[k+1] <= n_quo[k];
                r_neg[k+1] <= r_neg[k];
                r_ovf[k+1] <= r_ovf[k];
            end
            r_out <= sat_q(w_val);
        end
    end

    assign o_quot = r_out;

endmodule

### design/slu_checker.sv
// ----------------------------------------------------------------------------
// Segment line intersection checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "segment_line_intersection_unit_macros.svh"

module slu_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      o_in_ready,
    input  logic                      o_out_valid,
    input  logic                      i_out_ready,
    input  logic                      o_found,
    input  slu_pkg::t_q               o_cross_x,
    input  slu_pkg::t_q               o_cross_y,
    input  logic                      o_on_first,
    input  logic                      o_on_second
);

    `SLU_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_cross_x) && $stable(o_cross_y) && $stable(o_found))

    `SLU_ASSERT_NOW(a_ready_when_empty, !o_out_valid, o_in_ready)

    `SLU_ASSERT_NOW(a_none_is_zero, o_out_valid && !o_found, o_cross_x == '0 && o_cross_y == '0 && !o_on_first && !o_on_second)

endmodule

bind segment_line_intersection_unit slu_checker u_slu_checker (.*);

### tb/segment_line_intersection_unit_tb.sv
// ----------------------------------------------------------------------------
// Segment line intersection unit testbench
// Drives segment pairs through the valid/ready input channel and checks each
// result against an in-bench fixed-point predictor, in order, field by field.
// Covers directed corner cases, random pairs at several tolerances, random
// idling on both channels and a long output hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
module segment_line_intersection_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import slu_pkg::*;

    localparam int DRAIN_CYCLES = 120;

    typedef struct {
        bit     vert;
        longint slope;
        longint icpt;
        longint ax;
        longint ay;
        longint bx;
        longint by;
    } t_carrier;

    typedef struct {
        bit found;
        t_q cx;
        t_q cy;
        bit on1;
        bit on2;
    } t_cross;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [TOL_W-1:0]    i_cfg_wdata;
    logic                i_in_valid;
    logic                o_in_ready;
    t_q                  i_first_start_x;
    t_q                  i_first_start_y;
    t_q                  i_first_end_x;
    t_q                  i_first_end_y;
    t_q                  i_second_start_x;
    t_q                  i_second_start_y;
    t_q                  i_second_end_x;
    t_q                  i_second_end_y;
    logic                o_out_valid;
    logic                i_out_ready;
    logic                o_found;
    t_q                  o_cross_x;
    t_q                  o_cross_y;
    logic                o_on_first;
    logic                o_on_second;

    t_cross  expected_crossings[$];
    longint  tol_model;
    int      error_count;
    bit      no_idle;
    int      hold_off_cycles;

    segment_line_intersection_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_first_start_x  (i_first_start_x),
        .i_first_start_y  (i_first_start_y),
        .i_first_end_x    (i_first_end_x),
        .i_first_end_y    (i_first_end_y),
        .i_second_start_x (i_second_start_x),
        .i_second_start_y (i_second_start_y),
        .i_second_end_x   (i_second_end_x),
        .i_second_end_y   (i_second_end_y),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_found          (o_found),
        .o_cross_x        (o_cross_x),
        .o_cross_y        (o_cross_y),
        .o_on_first       (o_on_first),
        .o_on_second      (o_on_second)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint clamp_q(input longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint line_y(input t_carrier c, input longint x);
        return ((c.slope * x) >>> FRAC_BITS) + c.icpt;
    endfunction

    function automatic t_carrier make_carrier(input t_seg s);
        t_carrier c;
        longint   dx;
        longint   dy;
        c.ax = longint'(s.sx);
        c.ay = longint'(s.sy);
        c.bx = longint'(s.ex);
        c.by = longint'(s.ey);
        dx = c.bx - c.ax;
        dy = c.by - c.ay;
        c.slope = 0;
        if (dx == 0 || mag(dx) < tol_model) begin
            c.vert = 1'b1;
            c.icpt = c.ax;
        end else begin
            c.vert  = 1'b0;
            c.slope = clamp_q((dy * (64'sd1 <<< FRAC_BITS)) / dx);
            c.icpt  = clamp_q(c.ay - ((c.ax * c.slope) >>> FRAC_BITS));
        end
        return c;
    endfunction

    function automatic bit lies_on(input t_carrier c, input longint px, input longint py);
        longint hi;
        longint lo;
        hi = ((c.ax > c.bx) ? c.ax : c.bx) + tol_model;
        lo = ((c.ax < c.bx) ? c.ax : c.bx) - tol_model;
        if (px > hi || px < lo) begin
            return 1'b0;
        end
        hi = ((c.ay > c.by) ? c.ay : c.by) + tol_model;
        lo = ((c.ay < c.by) ? c.ay : c.by) - tol_model;
        if (py < lo || py > hi) begin
            return 1'b0;
        end
        if (c.vert) begin
            return mag(px - c.icpt) < tol_model;
        end
        return mag(py - line_y(c, px)) < tol_model;
    endfunction

    function automatic t_cross predict_crossing(input t_seg a, input t_seg b);
        t_carrier l1;
        t_carrier l2;
        t_cross   r;
        longint   px;
        longint   py;
        longint   dm;
        l1 = make_carrier(a);
        l2 = make_carrier(b);
        r.found = 1'b0;
        px = 0;
        py = 0;
        if (l1.vert && l2.vert) begin
            r.found = 1'b0;
        end else if (l1.vert) begin
            r.found = 1'b1;
            px = l1.icpt;
            py = clamp_q(line_y(l2, px));
        end else if (l2.vert) begin
            r.found = 1'b1;
            px = l2.icpt;
            py = clamp_q(line_y(l1, px));
        end else begin
            dm = l2.slope - l1.slope;
            if (!(dm == 0 || mag(dm) < tol_model)) begin
                r.found = 1'b1;
                px = clamp_q(((l1.icpt - l2.icpt) * (64'sd1 <<< FRAC_BITS)) / dm);
                py = clamp_q(line_y(l1, px));
            end
        end
        r.cx  = t_q'(px);
        r.cy  = t_q'(py);
        r.on1 = r.found && lies_on(l1, px, py);
        r.on2 = r.found && lies_on(l2, px, py);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_cross want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_crossings.size() == 0) begin
                report_mismatch("unexpected transaction", 1, 0);
            end else begin
                want = expected_crossings.pop_front();
                if (o_found !== want.found) report_mismatch("found", o_found, want.found);
                if (o_cross_x !== want.cx) report_mismatch("cross_x", o_cross_x, want.cx);
                if (o_cross_y !== want.cy) report_mismatch("cross_y", o_cross_y, want.cy);
                if (o_on_first !== want.on1) report_mismatch("on_first", o_on_first, want.on1);
                if (o_on_second !== want.on2) report_mismatch("on_second", o_on_second, want.on2);
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_out_ready     <= 1'b0;
        end else begin
            i_out_ready <= no_idle || ($urandom_range(99) >= 19);
        end
    end

    task automatic send_pair(input t_seg a, input t_seg b);
        while (!no_idle && $urandom_range(99) < 19) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_first_start_x  <= a.sx;
        i_first_start_y  <= a.sy;
        i_first_end_x    <= a.ex;
        i_first_end_y    <= a.ey;
        i_second_start_x <= b.sx;
        i_second_start_y <= b.sy;
        i_second_end_x   <= b.ex;
        i_second_end_y   <= b.ey;
        do @(posedge i_clk); while (!o_in_ready);
        expected_crossings.push_back(predict_crossing(a, b));
        @(negedge i_clk);
    endtask

    task automatic end_burst();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_tolerance(input logic [TOL_W-1:0] tol);
        while (expected_crossings.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= tol;
        @(negedge i_clk);
        i_cfg_we  <= 1'b0;
        tol_model = longint'(tol);
    endtask

    function automatic t_seg mk_seg(input longint sx, input longint sy,
                                    input longint ex, input longint ey);
        t_seg s;
        s.sx = t_q'(sx);
        s.sy = t_q'(sy);
        s.ex = t_q'(ex);
        s.ey = t_q'(ey);
        return s;
    endfunction

    function automatic t_q rand_coord();
        case ($urandom_range(3))
            0: return t_q'($urandom);
            1: return t_q'($signed($urandom_range(2 * 65536 * 64)) - 65536 * 64);
            default: return t_q'($signed($urandom_range(2 * 65536 * 8)) - 65536 * 8);
        endcase
    endfunction

    function automatic t_seg rand_seg();
        t_seg s;
        s.sx = rand_coord();
        s.sy = rand_coord();
        s.ey = rand_coord();
        case ($urandom_range(5))
            0: s.ex = s.sx;
            1: s.ex = s.sx + t_q'($urandom_range(20)) - 10;
            default: s.ex = rand_coord();
        endcase
        return s;
    endfunction

    task automatic test_directed();
        longint mx;
        longint mn;
        mx = 64'sd2147483647;
        mn = -64'sd2147483648;
        send_pair(mk_seg(0, 0, 65536, 65536), mk_seg(0, 65536, 65536, 0));
        send_pair(mk_seg(mx, mx, mx, mx), mk_seg(mx, mx, mx, mx));
        send_pair(mk_seg(mn, mn, mn, mn), mk_seg(mn, mn, mn, mn));
        send_pair(mk_seg(mn, mn, mx, mx), mk_seg(mn, mx, mx, mn));
        send_pair(mk_seg(mx, mn, mn, mx), mk_seg(0, 0, 1, mx));
        send_pair(mk_seg(mn, 0, mn + 1, mx), mk_seg(mx, 0, mx - 1, mn));
        send_pair(mk_seg(65536, 0, 65536, 65536), mk_seg(0, 32768, 131072, 32768));
        send_pair(mk_seg(0, 32768, 131072, 32768), mk_seg(65536, 0, 65536, 65536));
        send_pair(mk_seg(0, 0, 0, 65536), mk_seg(65536, 0, 65536, 65536));
        send_pair(mk_seg(0, 0, 3, 65536), mk_seg(65536, 0, 65540, 65536));
        send_pair(mk_seg(0, 0, 65536, 65536), mk_seg(0, 65536, 65536, 131072));
        send_pair(mk_seg(0, 0, 65536, 65536), mk_seg(0, 1, 65536, 65538));
        send_pair(mk_seg(0, 0, 65536, 0), mk_seg(0, 0, 65536, 0));
        send_pair(mk_seg(0, 0, 1, mx), mk_seg(0, 0, 1, mn));
        send_pair(mk_seg(mn, mn, mx, mn), mk_seg(mn, mx, mx, mx - 65536));
        send_pair(mk_seg(-65536, -65536, 65536, 65536), mk_seg(-65536, 65536, 65536, -65536));
        send_pair(mk_seg(131072, 0, 262144, 65536), mk_seg(0, 0, 65536, 131072));
        send_pair(mk_seg(-1, -1, -65537, -1), mk_seg(0, -65536, 0, 65536));
        end_burst();
    endtask

    task automatic test_random(input int count, input bit quiet);
        t_seg a;
        t_seg b;
        no_idle = quiet;
        for (int i = 0; i < count; i++) begin
            a = rand_seg();
            if ($urandom_range(9) == 0) begin
                b.sx = a.sx + t_q'($urandom_range(65536));
                b.sy = a.sy + t_q'($urandom_range(65536));
                b.ex = a.ex + (b.sx - a.sx);
                b.ey = a.ey + (b.sy - a.sy);
            end else begin
                b = rand_seg();
            end
            send_pair(a, b);
        end
        end_burst();
        no_idle = 1'b0;
    endtask

    task automatic test_zero_tolerance();
        set_tolerance('0);
        test_directed();
        test_random(200, 1'b0);
    endtask

    task automatic test_max_tolerance();
        set_tolerance('1);
        test_directed();
        test_random(200, 1'b0);
    endtask

    task automatic test_output_stall();
        @(negedge i_clk);
        hold_off_cycles = 300;
        test_random(200, 1'b1);
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = '0;
        i_in_valid       = 1'b0;
        i_out_ready      = 1'b0;
        i_first_start_x  = '0;
        i_first_start_y  = '0;
        i_first_end_x    = '0;
        i_first_end_y    = '0;
        i_second_start_x = '0;
        i_second_start_y = '0;
        i_second_end_x   = '0;
        i_second_end_y   = '0;
        tol_model        = longint'(TOL_RESET);
        error_count      = 0;
        no_idle          = 1'b0;
        hold_off_cycles  = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(500, 1'b0);
        test_random(200, 1'b1);
        test_output_stall();
        test_zero_tolerance();
        test_max_tolerance();
        set_tolerance(TOL_W'($urandom_range(1, 200)));
        test_random(300, 1'b0);
        set_tolerance(TOL_W'($urandom));
        test_random(200, 1'b0);

        while (expected_crossings.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_crossings.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

### segment_line_intersection_unit.f
+incdir+design
design/slu_pkg.sv
design/slu_div.sv
design/segment_line_intersection_unit.sv
design/slu_checker.sv
tb/segment_line_intersection_unit_tb.sv
